@@ rtl/integer_square_root_defines.svh @@
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define ISR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isr assertion failed");

// Next-cycle implication, checked on clk, disabled in reset.
`define ISR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isr assertion failed");

`endif

@@ rtl/isr_pkg.sv @@
`default_nettype none

package isr_pkg;

    localparam int DEFAULT_OPERAND_BITS = 64;
    localparam int OPERAND_W            = 64;
    localparam int ROOT_W               = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } isr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } isr_cmd_t;

endpackage

`default_nettype wire

@@ rtl/isr_ctrl.sv @@
`default_nettype none

module isr_ctrl
    import isr_pkg::*;
#(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output isr_cmd_t      cmd,
    output logic          busy,
    output logic          done
);

    localparam int ROOT_BITS = (OPERAND_BITS + 1) / 2;
    localparam int CNT_W     = $clog2(ROOT_BITS + 1);

    isr_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    count_next = CNT_W'(ROOT_BITS - 1);
                end
            end
            ST_RUN:
            begin
                if (count_reg == '0)
                    state_next = ST_DONE;
                else
                    count_next = count_reg - 1'b1;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        busy     = 1'b1;
        done     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/isr_datapath.sv @@
`default_nettype none

module isr_datapath
    import isr_pkg::*;
#(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
)
(
    input  wire logic                 clk,
    input  wire isr_cmd_t             cmd,
    input  wire logic [OPERAND_W-1:0] operand,
    output logic [ROOT_W-1:0]         root,
    output logic                      inexact
);

    localparam int ROOT_BITS = (OPERAND_BITS + 1) / 2;
    localparam int PAD_W     = 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 3;

    logic [PAD_W-1:0]     rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             keep;

    // one root bit per step: bring down two radicand bits, try 4q+1
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[PAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign diff      = rem_shift - trial;
    assign keep      = (rem_shift >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            rad_next  = PAD_W'(operand[OPERAND_BITS-1:0]);
            rem_next  = '0;
            root_next = '0;
        end
        else if (cmd.step)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = keep ? diff : rem_shift;
            root_next = ROOT_BITS'({root_reg, keep});
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root    = ROOT_W'(root_reg);
    assign inexact = |rem_reg;

endmodule

`default_nettype wire

@@ rtl/integer_square_root.sv @@
// Channel   Handshake                 Payload
// input     start & !busy (accept)    operand[63:0]
// result    done (one-cycle strobe)   root[31:0], inexact
//
// After the accept, the controller steps through ST_RUN, one root bit per step, and
// then raises done in ST_DONE. A new operand cannot be accepted before the previous
// done strobe has passed. The single shared subtract/compare settles one root bit
// per cycle. busy stays high until the strobe has passed; start is ignored while
// busy. The receiver cannot stall; it must take the results in the done cycle, which
// the block itself does not enforce. rst_n clears the controller only.
`default_nettype none

`include "integer_square_root_defines.svh"

module integer_square_root
    import isr_pkg::*;
#(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [OPERAND_W-1:0] operand,
    output logic                      busy,
    output logic                      done,
    output logic [ROOT_W-1:0]         root,
    output logic                      inexact
);

    localparam int ROOT_BITS = (OPERAND_BITS + 1) / 2;

    isr_cmd_t cmd;

    isr_ctrl #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    isr_datapath #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .operand (operand),
        .root    (root),
        .inexact (inexact)
    );

    `ISR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `ISR_ASSERT_NEXT(a_done_release, done, !busy && !done)
    `ISR_ASSERT_NOW(a_accept_latency, start && !busy, ##(ROOT_BITS + 1) done)
    `ISR_ASSERT_NOW(a_load_only_idle, cmd.load, !busy && !cmd.step)

endmodule

`default_nettype wire
